[rtl/fawot_pkg.sv]
// Package for the frame allocator with owner table.
// Holds command codes, field widths and default sizes; depends on nothing.
`default_nettype none

package fawot_pkg;

  // Default number of managed frames.
  localparam int FRAMES_DEF = 64;

  // Fixed field widths of the command and result ports.
  localparam int CMD_W   = 2;
  localparam int OWNER_W = 8;
  localparam int SIZE_W  = 7;

  // One RAM word holds the free flag above the owner tag.
  localparam int ENTRY_W = OWNER_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

endpackage

`default_nettype wire

[rtl/fawot_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Width and depth come from parameters; defaults from fawot_pkg.
`default_nettype none

module fawot_ram #(
  parameter int WIDTH = fawot_pkg::ENTRY_W,
  parameter int DEPTH = fawot_pkg::FRAMES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/frame_allocator_with_owner_table.sv]
// Frame allocator with owner table: top level. Uses fawot_pkg and fawot_ram.
// Query, zero-size allocate, refused allocate and unused commands answer in the
// cycle after the start transfer; a granted allocate or a release answers after
// a scan of every frame. One command at a time: busy stays high until the result
// strobe has been shown, and the scan reads one RAM entry per cycle. After reset a
// clearing pass marks every frame free, with busy high. The receiver cannot stall:
// done lasts one cycle.
`default_nettype none

module frame_allocator_with_owner_table #(
  parameter int FRAMES = fawot_pkg::FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fawot_pkg::CMD_W-1:0]   command,
  input  wire logic [fawot_pkg::OWNER_W-1:0] owner_id,
  input  wire logic [fawot_pkg::SIZE_W-1:0]  request_size,
  output logic                               done,
  output logic                               success,
  output logic      [fawot_pkg::SIZE_W-1:0]  free_frames
);

  // Index width, free counter width, and a width that holds both the
  // request size and the counter for the sufficiency compare.
  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int WW = (CW > fawot_pkg::SIZE_W) ? CW : fawot_pkg::SIZE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

  // Sequencer states.
  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]                      state;
  logic [IW-1:0]                   idx;         // next frame to read, or to clear
  logic                            issue_done;  // every frame has been read
  logic                            rd_valid;    // RAM output holds frame rd_idx
  logic                            rd_last;     // that frame is the last one
  logic [IW-1:0]                   rd_idx;
  logic [CW-1:0]                   cnt;         // free frame count
  logic [fawot_pkg::SIZE_W-1:0]    taken;       // frames claimed by this allocate
  logic [fawot_pkg::CMD_W-1:0]     cmd;
  logic [fawot_pkg::OWNER_W-1:0]   owner;
  logic [fawot_pkg::SIZE_W-1:0]    want;

  // RAM port signals.
  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr;
  logic [fawot_pkg::ENTRY_W-1:0]   ram_wdata;
  logic                            ram_re;
  logic [fawot_pkg::ENTRY_W-1:0]   ram_rdata;

  // Decoded fields of the entry that the RAM just returned.
  logic                            ent_free;
  logic [fawot_pkg::OWNER_W-1:0]   ent_owner;
  logic                            claim;       // allocate takes this frame
  logic                            give_back;   // release frees this frame
  logic                            too_big;     // request exceeds free count

  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_RESP);
  assign free_frames = fawot_pkg::SIZE_W'(cnt);

  assign ent_free  = ram_rdata[fawot_pkg::OWNER_W];
  assign ent_owner = ram_rdata[fawot_pkg::OWNER_W-1:0];
  assign too_big   = WW'(request_size) > WW'(cnt);

  // A frame is claimed while the allocate still needs more; a release only
  // looks at taken frames, so the owner tag left in a free frame never
  // counts.
  assign claim     = (state == ST_SCAN) && rd_valid && (cmd == fawot_pkg::CMD_ALLOC) &&
                     ent_free && (taken < want);
  assign give_back = (state == ST_SCAN) && rd_valid && (cmd == fawot_pkg::CMD_RELEASE) &&
                     !ent_free && (ent_owner == owner);

  // RAM control. The read runs one frame ahead of the write, so a read and a
  // write in the same cycle never meet at one address.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = {1'b1, owner};
    ram_re    = 1'b0;
    if (state == ST_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = {1'b1, {fawot_pkg::OWNER_W{1'b0}}};
    end else if (claim) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b0, owner};
    end else if (give_back) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, ent_owner};
    end
    if (state == ST_SCAN && !issue_done) begin
      ram_re = 1'b1;
    end
  end

  fawot_ram #(
    .WIDTH (fawot_pkg::ENTRY_W),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Sequencer. Commands that need no scan answer straight from the free
  // counter; a granted allocate and a release walk every frame once.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      idx      <= '0;
      rd_valid <= 1'b0;
      cnt      <= CW'(FRAMES);
    end else begin
      unique case (state)
        ST_INIT: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            cmd        <= command;
            owner      <= owner_id;
            want       <= request_size;
            idx        <= '0;
            issue_done <= 1'b0;
            taken      <= '0;
            rd_valid   <= 1'b0;
            unique case (command)
              fawot_pkg::CMD_ALLOC: begin
                // A zero-size request is granted without touching any frame;
                // an oversize one is refused with no change.
                if (request_size == '0) begin
                  success <= 1'b1;
                  state   <= ST_RESP;
                end else if (too_big) begin
                  success <= 1'b0;
                  state   <= ST_RESP;
                end else begin
                  state <= ST_SCAN;
                end
              end
              fawot_pkg::CMD_RELEASE: begin
                state <= ST_SCAN;
              end
              fawot_pkg::CMD_QUERY: begin
                success <= !too_big;
                state   <= ST_RESP;
              end
              default: begin
                // The unused command code changes nothing and reports failure.
                success <= 1'b0;
                state   <= ST_RESP;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // Issue side: one read per cycle until the last frame is read.
          rd_valid <= !issue_done;
          rd_last  <= !issue_done && (idx == LAST_IDX);
          rd_idx   <= idx;
          if (!issue_done) begin
            idx <= idx + 1'b1;
            if (idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end
          end
          // Update side: keep the free counter in step with the RAM writes.
          if (claim) begin
            taken <= taken + 1'b1;
            cnt   <= cnt - 1'b1;
          end else if (give_back) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_valid && rd_last) begin
            success <= 1'b1;
            state   <= ST_RESP;
          end
        end

        ST_RESP: begin
          state <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
